/* src/ethernet_llc_arp_header_classifier_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the LLC/ARP header classifier
// Shared concurrent assertion forms, clocked on aclk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ETHERNET_LLC_ARP_HEADER_CLASSIFIER_UNIT_MACROS_SVH
`define ETHERNET_LLC_ARP_HEADER_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication.
`define ELLC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication.
`define ELLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

/* src/ellc_pkg.sv */
// ----------------------------------------------------------------------------
// ellc_pkg
// Types and constants of the Ethernet LLC/ARP header classifier.
// ----------------------------------------------------------------------------
package ellc_pkg;

    // Byte positions within the frame
    localparam logic [5:0] POS_SRC     = 6'd6;
    localparam logic [5:0] POS_TYPE    = 6'd12;
    localparam logic [5:0] POS_PAYLOAD = 6'd14;
    localparam logic [5:0] POS_SAP     = 6'd15;
    localparam logic [5:0] POS_CTL1    = 6'd16;
    localparam logic [5:0] POS_CTL2    = 6'd17;
    localparam logic [5:0] POS_OP_HI   = 6'd20;
    localparam logic [5:0] POS_OP_LO   = 6'd21;
    localparam logic [5:0] POS_MAX     = 6'd63;

    // Type/length word values
    localparam logic [15:0] LLC_MAX_LEN    = 16'd1500;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;

    // ARP opcodes
    localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
    localparam logic [15:0] ARP_OP_REPLY   = 16'd2;

    // Minimum frame lengths per kind
    localparam logic [6:0] NEED_BASIC = 7'd14;
    localparam logic [6:0] NEED_LLC_U = 7'd17;
    localparam logic [6:0] NEED_LLC_IS = 7'd18;
    localparam logic [6:0] NEED_ARP   = 7'd22;

    // Frame kind codes
    localparam logic [1:0] KIND_LLC   = 2'd0;
    localparam logic [1:0] KIND_IPV4  = 2'd1;
    localparam logic [1:0] KIND_ARP   = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    // LLC format codes
    localparam logic [1:0] FMT_I       = 2'd0;
    localparam logic [1:0] FMT_S       = 2'd1;
    localparam logic [1:0] FMT_U       = 2'd2;
    localparam logic [1:0] FMT_NOT_LLC = 2'd3;

    // ARP operation codes
    localparam logic [1:0] ARP_REQUEST = 2'd0;
    localparam logic [1:0] ARP_REPLY   = 2'd1;
    localparam logic [1:0] ARP_OTHER   = 2'd2;
    localparam logic [1:0] ARP_NONE    = 2'd3;

    // Captured header bytes
    typedef struct packed {
        logic [47:0] dest;
        logic [47:0] source;
        logic [15:0] type_len;
        logic [7:0]  sap;
        logic [7:0]  ctl1;
        logic [7:0]  ctl2;
        logic [15:0] opcode;
    } hdr_t;

    // One classification result
    typedef struct packed {
        logic [47:0] dest_address;
        logic [47:0] source_address;
        logic [15:0] type_or_length;
        logic [1:0]  frame_kind;
        logic        short_frame;
        logic [1:0]  llc_format;
        logic [6:0]  send_sequence;
        logic [6:0]  receive_sequence;
        logic [4:0]  control_code;
        logic        poll_final;
        logic        is_response;
        logic [1:0]  arp_operation;
    } result_t;

endpackage

/* src/ellc_decode.sv */
// ----------------------------------------------------------------------------
// ellc_decode
// Classifies a captured header: frame kind, LLC control field, ARP opcode, short-frame flag.
// ----------------------------------------------------------------------------
module ellc_decode (
    input  ellc_pkg::hdr_t    hdr,
    input  logic [6:0]        byte_count,
    output ellc_pkg::result_t res
);

    logic [6:0] need;

    always_comb begin
        res                  = '0;
        res.dest_address     = hdr.dest;
        res.source_address   = hdr.source;
        res.type_or_length   = hdr.type_len;
        res.llc_format       = ellc_pkg::FMT_NOT_LLC;
        res.arp_operation    = ellc_pkg::ARP_NONE;
        need                 = ellc_pkg::NEED_BASIC;

        // Pick the kind from the type/length word
        priority if (hdr.type_len <= ellc_pkg::LLC_MAX_LEN) begin
            res.frame_kind  = ellc_pkg::KIND_LLC;
            res.is_response = hdr.sap[0];
            // Decode the control field: bit0 clear is I, 01 is S, 11 is U
            priority if (!hdr.ctl1[0]) begin
                res.llc_format       = ellc_pkg::FMT_I;
                res.send_sequence    = hdr.ctl1[7:1];
                res.receive_sequence = hdr.ctl2[7:1];
                res.poll_final       = hdr.ctl2[0];
                need                 = ellc_pkg::NEED_LLC_IS;
            end else if (!hdr.ctl1[1]) begin
                res.llc_format       = ellc_pkg::FMT_S;
                res.receive_sequence = hdr.ctl2[7:1];
                res.control_code     = {3'b000, hdr.ctl1[3:2]};
                res.poll_final       = hdr.ctl2[0];
                need                 = ellc_pkg::NEED_LLC_IS;
            end else begin
                res.llc_format   = ellc_pkg::FMT_U;
                res.control_code = {hdr.ctl1[7:5], hdr.ctl1[3:2]};
                res.poll_final   = hdr.ctl1[4];
                need             = ellc_pkg::NEED_LLC_U;
            end
        end else if (hdr.type_len == ellc_pkg::ETHERTYPE_IPV4) begin
            res.frame_kind = ellc_pkg::KIND_IPV4;
        end else if (hdr.type_len == ellc_pkg::ETHERTYPE_ARP) begin
            res.frame_kind = ellc_pkg::KIND_ARP;
            need           = ellc_pkg::NEED_ARP;
            priority if (hdr.opcode == ellc_pkg::ARP_OP_REQUEST) begin
                res.arp_operation = ellc_pkg::ARP_REQUEST;
            end else if (hdr.opcode == ellc_pkg::ARP_OP_REPLY) begin
                res.arp_operation = ellc_pkg::ARP_REPLY;
            end else begin
                res.arp_operation = ellc_pkg::ARP_OTHER;
            end
        end else begin
            res.frame_kind = ellc_pkg::KIND_OTHER;
        end

        // Flag frames that ended before the fields their kind needs
        res.short_frame = (byte_count < need);
    end

endmodule

/* src/ethernet_llc_arp_header_classifier_unit.sv */
// ----------------------------------------------------------------------------
// ethernet_llc_arp_header_classifier_unit
// Ethernet header parser with LLC control decode and ARP opcode check.
// ----------------------------------------------------------------------------
// The block takes one frame byte per beat and accepts a beat in every cycle
// in which s_ready is high. Header bytes are captured as they pass; on the
// beat marked last the classification is decoded in the same cycle and lands
// in the result register, so the result beat is offered in the cycle after
// the last byte, and the next frame may start in the very next cycle if
// m_ready is high. The result register is the only buffer on the output
// side: s_ready drops only while a result is held and m_ready is low; only
// combinational decode logic lies between the capture and result registers.
module ethernet_llc_arp_header_classifier_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_frame_byte,
    input  logic        s_frame_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [47:0] m_dest_address,
    output logic [47:0] m_source_address,
    output logic [15:0] m_type_or_length,
    output logic [1:0]  m_frame_kind,
    output logic        m_short_frame,
    output logic [1:0]  m_llc_format,
    output logic [6:0]  m_send_sequence,
    output logic [6:0]  m_receive_sequence,
    output logic [4:0]  m_control_code,
    output logic        m_poll_final,
    output logic        m_is_response,
    output logic [1:0]  m_arp_operation
);

    logic              s_accept;
    logic [5:0]        pos_reg, pos_next, pos_upd;
    ellc_pkg::hdr_t    hdr_reg, hdr_next, hdr_upd;
    ellc_pkg::result_t res;
    ellc_pkg::result_t res_reg;
    logic              m_valid_reg, m_valid_next;

    // Take a beat while the result register is free or being drained
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // Capture the header byte at the current position
    always_comb begin
        hdr_upd = hdr_reg;
        priority if (pos_reg < ellc_pkg::POS_SRC) begin
            hdr_upd.dest = {hdr_reg.dest[39:0], s_frame_byte};
        end else if (pos_reg < ellc_pkg::POS_TYPE) begin
            hdr_upd.source = {hdr_reg.source[39:0], s_frame_byte};
        end else if (pos_reg < ellc_pkg::POS_PAYLOAD) begin
            hdr_upd.type_len = {hdr_reg.type_len[7:0], s_frame_byte};
        end else if (pos_reg == ellc_pkg::POS_SAP) begin
            hdr_upd.sap = s_frame_byte;
        end else if (pos_reg == ellc_pkg::POS_CTL1) begin
            hdr_upd.ctl1 = s_frame_byte;
        end else if (pos_reg == ellc_pkg::POS_CTL2) begin
            hdr_upd.ctl2 = s_frame_byte;
        end else if (pos_reg == ellc_pkg::POS_OP_HI || pos_reg == ellc_pkg::POS_OP_LO) begin
            hdr_upd.opcode = {hdr_reg.opcode[7:0], s_frame_byte};
        end else begin
            hdr_upd = hdr_reg;
        end
        // Advance the position, saturating
        pos_upd = (pos_reg < ellc_pkg::POS_MAX) ? (pos_reg + 6'd1) : pos_reg;
    end

    // Decode from the header including this beat's byte
    ellc_decode u_decode (
        .hdr        (hdr_upd),
        .byte_count ({1'b0, pos_reg} + 7'd1),
        .res        (res)
    );

    // Advance capture state; clear it after the last byte
    always_comb begin
        hdr_next     = hdr_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (s_accept) begin
            if (s_frame_last) begin
                hdr_next     = '0;
                pos_next     = '0;
                m_valid_next = 1'b1;
            end else begin
                hdr_next = hdr_upd;
                pos_next = pos_upd;
            end
        end
    end

    // Hold control and capture state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg     <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            hdr_reg     <= hdr_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Load the result register on the last beat
    always_ff @(posedge aclk) begin
        if (s_accept && s_frame_last) begin
            res_reg <= res;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_dest_address     = res_reg.dest_address;
    assign m_source_address   = res_reg.source_address;
    assign m_type_or_length   = res_reg.type_or_length;
    assign m_frame_kind       = res_reg.frame_kind;
    assign m_short_frame      = res_reg.short_frame;
    assign m_llc_format       = res_reg.llc_format;
    assign m_send_sequence    = res_reg.send_sequence;
    assign m_receive_sequence = res_reg.receive_sequence;
    assign m_control_code     = res_reg.control_code;
    assign m_poll_final       = res_reg.poll_final;
    assign m_is_response      = res_reg.is_response;
    assign m_arp_operation    = res_reg.arp_operation;

endmodule

/* src/ellc_checker.sv */
// ----------------------------------------------------------------------------
// ellc_checker
// Port-level assertions for the header classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "ethernet_llc_arp_header_classifier_unit_macros.svh"

module ellc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_frame_byte,
    input logic        s_frame_last,
    input logic        m_valid,
    input logic        m_ready,
    input logic [47:0] m_dest_address,
    input logic [47:0] m_source_address,
    input logic [15:0] m_type_or_length,
    input logic [1:0]  m_frame_kind,
    input logic        m_short_frame,
    input logic [1:0]  m_llc_format,
    input logic [6:0]  m_send_sequence,
    input logic [6:0]  m_receive_sequence,
    input logic [4:0]  m_control_code,
    input logic        m_poll_final,
    input logic        m_is_response,
    input logic [1:0]  m_arp_operation
);

    // A stalled result beat holds
    `ELLC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_dest_address) && $stable(m_frame_kind) && $stable(m_llc_format))

    // Only ARP frames carry an opcode class
    `ELLC_ASSERT_IMPLY(a_arp_only, aclk, aresetn, m_valid && (m_frame_kind != ellc_pkg::KIND_ARP), m_arp_operation == ellc_pkg::ARP_NONE)

    // Only LLC frames carry control decode
    `ELLC_ASSERT_IMPLY(a_llc_only, aclk, aresetn, m_valid && (m_frame_kind != ellc_pkg::KIND_LLC), (m_llc_format == ellc_pkg::FMT_NOT_LLC) && !m_is_response && !m_poll_final)

    // U frames carry no sequence numbers
    `ELLC_ASSERT_IMPLY(a_u_no_seq, aclk, aresetn, m_valid && (m_llc_format == ellc_pkg::FMT_U), (m_send_sequence == 7'd0) && (m_receive_sequence == 7'd0))

endmodule

bind ethernet_llc_arp_header_classifier_unit ellc_checker u_ellc_checker (.*);
